// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the packer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define LBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define LBP_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== rtl/lbp_pkg.sv =====
// ----------------------------------------------------------------------------
// lbp_pkg
// Types and constants shared by the modules of the LSB-first bit packer.
// ----------------------------------------------------------------------------
package lbp_pkg;

  // Field and state widths.
  localparam int VALUE_W    = 32;
  localparam int WIDTH_W    = 6;
  localparam int POS_W      = 20;
  localparam int COUNT_W    = 19;
  localparam int CAP_W      = 16;
  localparam int NBYTES_W   = 3;
  localparam int BYTE_IDX_W = 2;
  localparam int ACC_W      = VALUE_W + 8;

  // Widest field that may be written; the value port carries 32 bits.
  localparam int MAX_FIELD_WIDTH = 32;
  localparam int WIDTH_LIMIT     = (MAX_FIELD_WIDTH < VALUE_W) ? MAX_FIELD_WIDTH : VALUE_W;

  // Reset value of the capacity register, in bytes.
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'd1024;

  // Default number of entries between front and back.
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // One classified word, waiting to be turned into result words.
  typedef struct packed {
    logic [ACC_W-1:0]    acc;        // bytes to emit, first byte lowest
    logic [NBYTES_W-1:0] nbytes;     // number of complete bytes, 0 to 4
    logic                status;     // 1 if the word was refused
    logic [COUNT_W-1:0]  bit_count;  // bits in the packet after this word
  } entry_t;

endpackage

// ===== rtl/lbp_front.sv =====
// ----------------------------------------------------------------------------
// lbp_front
// Accepts input words, keeps the packet state and classifies each word into
// a queue entry that holds all the bytes it completes.
// ----------------------------------------------------------------------------
module lbp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [lbp_pkg::CAP_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        op,
  input  logic [lbp_pkg::VALUE_W-1:0] field_value,
  input  logic [lbp_pkg::WIDTH_W-1:0] field_width,
  input  logic                        queue_full,
  output logic                        push,
  output lbp_pkg::entry_t             push_entry
);
  import lbp_pkg::*;

  logic [CAP_W-1:0]   capacity;
  logic [POS_W-1:0]   bit_position;
  logic [7:0]         partial_bits;
  logic               error_flag;

  logic [POS_W-1:0]   bit_position_next;
  logic [7:0]         partial_bits_next;
  logic               error_flag_next;

  logic [2:0]         fill;
  logic [VALUE_W-1:0] mask;
  logic [ACC_W-1:0]   acc;
  logic [WIDTH_W-1:0] total;
  logic [NBYTES_W-1:0] nbytes;
  logic               too_wide;
  logic               over_capacity;
  logic [POS_W:0]     end_position;
  logic [POS_W:0]     capacity_bits;

  // A word is taken whenever the queue has room and reset is not asserted.
  assign in_stall = rst | queue_full;
  assign push     = in_valid & ~in_stall;

  // Bit insertion for a write: mask the value and shift it above the pending bits.
  assign fill          = bit_position[2:0];
  assign mask          = (field_width == '0) ? '0
                       : ({VALUE_W{1'b1}} >> (WIDTH_W'(VALUE_W) - field_width));
  assign acc           = {{(ACC_W-8){1'b0}}, partial_bits}
                       | ({8'd0, field_value & mask} << fill);
  assign total         = {{(WIDTH_W-3){1'b0}}, fill} + field_width;
  assign nbytes        = total[WIDTH_W-1:3];

  // Limit checks.
  assign too_wide      = field_width > WIDTH_W'(WIDTH_LIMIT);
  assign end_position  = {1'b0, bit_position} + (POS_W+1)'(field_width);
  assign capacity_bits = {2'b00, capacity, 3'b000};
  assign over_capacity = end_position > capacity_bits;

  // Classification of the word and the state it leaves behind.
  always_comb begin
    bit_position_next    = bit_position;
    partial_bits_next    = partial_bits;
    error_flag_next      = error_flag;
    push_entry.acc       = '0;
    push_entry.nbytes    = '0;
    push_entry.status    = 1'b0;
    push_entry.bit_count = bit_position[COUNT_W-1:0];
    if (op == OP_FLUSH) begin
      bit_position_next    = '0;
      partial_bits_next    = '0;
      error_flag_next      = 1'b0;
      push_entry.acc       = {{(ACC_W-8){1'b0}}, partial_bits};
      push_entry.nbytes    = (fill != 3'd0) ? NBYTES_W'(1) : '0;
      push_entry.bit_count = '0;
    end else if (error_flag) begin
      push_entry.status = 1'b1;
    end else if (field_width == '0) begin
      push_entry.status = 1'b0;
    end else if (too_wide || over_capacity) begin
      error_flag_next   = 1'b1;
      push_entry.status = 1'b1;
    end else begin
      bit_position_next    = end_position[POS_W-1:0];
      partial_bits_next    = acc[{nbytes[BYTE_IDX_W:0], 3'b000} +: 8];
      push_entry.acc       = acc;
      push_entry.nbytes    = nbytes;
      push_entry.bit_count = end_position[COUNT_W-1:0];
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_write) begin
      capacity <= cfg_data;
    end
  end

  // Packet state, updated as each word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position <= '0;
      partial_bits <= '0;
      error_flag   <= 1'b0;
    end else if (push) begin
      bit_position <= bit_position_next;
      partial_bits <= partial_bits_next;
      error_flag   <= error_flag_next;
    end
  end

endmodule

// ===== rtl/lbp_queue.sv =====
// ----------------------------------------------------------------------------
// lbp_queue
// Short first-in first-out queue of classified entries between the front
// and the back of the packer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbp_queue #(
  parameter int DEPTH = lbp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lbp_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output lbp_pkg::entry_t head
);
  import lbp_pkg::*;

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_QW = $clog2(DEPTH + 1);

  entry_t               slots [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [COUNT_QW-1:0]  count;

  assign full  = count == COUNT_QW'(DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + COUNT_QW'(1);
      end else if (pop && !push) begin
        count <= count - COUNT_QW'(1);
      end
    end
  end

  // The level never runs past either end, and rises on a push without a pop.
  `LBP_ASSERT(a_no_overflow, !(full && push), "push into a full queue")
  `LBP_ASSERT(a_no_underflow, !(empty && pop), "pop from an empty queue")
  `LBP_ASSERT_NEXT(a_level_up, push && !pop, count == $past(count) + COUNT_QW'(1), "queue level did not rise")

endmodule

// ===== rtl/lbp_back.sv =====
// ----------------------------------------------------------------------------
// lbp_back
// Drains queue entries into result words, one byte per cycle while the output
// is not stalled, through an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        empty,
  input  lbp_pkg::entry_t             head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        byte_valid,
  output logic                        status,
  output logic [lbp_pkg::COUNT_W-1:0] bit_count,
  output logic                        last
);
  import lbp_pkg::*;

  logic [BYTE_IDX_W-1:0] idx;
  logic                  load;
  logic                  has_bytes;
  logic                  res_last;

  // A new result word enters the output register when it is free or moving on.
  assign load      = !empty && (!out_valid || !out_stall);
  assign has_bytes = head.nbytes != '0;
  assign res_last  = !has_bytes || (({1'b0, idx} + NBYTES_W'(1)) == head.nbytes);
  assign pop       = load && res_last;

  // Byte index within the head entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= res_last ? '0 : idx + BYTE_IDX_W'(1);
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= has_bytes ? head.acc[{idx, 3'b000} +: 8] : 8'd0;
      byte_valid <= has_bytes;
      status     <= head.status;
      bit_count  <= head.bit_count;
      last       <= res_last;
    end
  end

  // The index stays inside the head entry, and only the last word may be byteless.
  `LBP_ASSERT(a_idx_in_entry, empty || !has_bytes || ({1'b0, idx} < head.nbytes), "byte index past entry")
  `LBP_ASSERT(a_mid_has_byte, !out_valid || last || byte_valid, "non-final word without a byte")

endmodule

// ===== rtl/lsb_first_bit_packer.sv =====
// Path: with the queue empty and the output free, the first result word of an input word
// goes from the queue slot it is written to into the output register.
// Throughput: one input word per cycle while each completes at most one byte and the output
// is not stalled; a word that completes n bytes (up to 4) yields n result words in turn.
// The front keeps a QUEUE_DEPTH-entry queue (default 4) and stalls when it is full.
// Reset: rst is synchronous; it clears the packet state and queue and sets the
// capacity register to 1024 bytes; the input also stalls while rst is high.
// ----------------------------------------------------------------------------
// lsb_first_bit_packer
// Packs fields of 0 to 32 bits, low bit first, into a byte stream with a
// sticky error for over-wide fields or capacity overflow and a flush word.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer #(
  parameter int QUEUE_DEPTH = lbp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [lbp_pkg::CAP_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        op,
  input  logic [lbp_pkg::VALUE_W-1:0] field_value,
  input  logic [lbp_pkg::WIDTH_W-1:0] field_width,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        byte_valid,
  output logic                        status,
  output logic [lbp_pkg::COUNT_W-1:0] bit_count,
  output logic                        last
);
  import lbp_pkg::*;

  logic   queue_full;
  logic   queue_empty;
  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t head;

  // Front: takes words and classifies them.
  lbp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .field_value (field_value),
    .field_width (field_width),
    .queue_full  (queue_full),
    .push        (push),
    .push_entry  (push_entry)
  );

  // Queue between the two halves.
  lbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .empty      (queue_empty),
    .head       (head)
  );

  // Back: emits the result words.
  lbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (queue_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .status     (status),
    .bit_count  (bit_count),
    .last       (last)
  );

endmodule

// ===== tb/sv/tb_lsb_first_bit_packer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lsb_first_bit_packer
// Self-checking bench for the LSB-first bit packer. A behavioural copy of the
// packet state predicts every output word from the words the block accepts.
// A directed opening pass is followed by random packets under several buffer
// capacities, with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------

// One output word as the block presents it.
typedef struct packed {
  logic [7:0]                  out_byte;
  logic                        byte_valid;
  logic                        status;
  logic [lbp_pkg::COUNT_W-1:0] bit_count;
  logic                        last;
} packer_result_t;

// Tracks the packet state and holds the output words still to come.
class bit_stream_scoreboard;
  logic [lbp_pkg::CAP_W-1:0] capacity_bytes;
  logic [lbp_pkg::POS_W-1:0] bit_pos;
  logic [7:0]                pending_bits;
  bit                        sticky_error;
  packer_result_t            expected_q[$];
  int unsigned               fail_count;

  function new();
    capacity_bytes = lbp_pkg::CAPACITY_RESET;
    bit_pos        = '0;
    pending_bits   = '0;
    sticky_error   = 1'b0;
    fail_count     = 0;
  endfunction

  function void push_result(logic [7:0] b, logic bv, logic st,
                            logic [lbp_pkg::COUNT_W-1:0] cnt, logic lst);
    packer_result_t r;
    r.out_byte   = b;
    r.byte_valid = bv;
    r.status     = st;
    r.bit_count  = cnt;
    r.last       = lst;
    expected_q   = {expected_q, r};
  endfunction

  // Works out the output words caused by one accepted input word.
  function void note_word(logic o, logic [lbp_pkg::VALUE_W-1:0] v,
                          logic [lbp_pkg::WIDTH_W-1:0] w);
    logic [lbp_pkg::VALUE_W-1:0] mask;
    logic [lbp_pkg::ACC_W-1:0]   acc;
    logic [7:0]                  keep;
    int unsigned                 fill;
    int unsigned                 total;
    int unsigned                 nbytes;
    fill = bit_pos[2:0];
    if (o == lbp_pkg::OP_FLUSH) begin
      // A flush pads out the partial byte and starts a fresh packet.
      push_result((fill != 0) ? pending_bits : 8'h00, fill != 0, 1'b0, '0, 1'b1);
      bit_pos      = '0;
      pending_bits = '0;
      sticky_error = 1'b0;
      return;
    end
    if (sticky_error) begin
      push_result(8'h00, 1'b0, 1'b1, bit_pos[lbp_pkg::COUNT_W-1:0], 1'b1);
      return;
    end
    if (w == '0) begin
      push_result(8'h00, 1'b0, 1'b0, bit_pos[lbp_pkg::COUNT_W-1:0], 1'b1);
      return;
    end
    if (int'(w) > lbp_pkg::WIDTH_LIMIT ||
        int'(bit_pos) + int'(w) > 8 * int'(capacity_bytes)) begin
      sticky_error = 1'b1;
      push_result(8'h00, 1'b0, 1'b1, bit_pos[lbp_pkg::COUNT_W-1:0], 1'b1);
      return;
    end
    // Append the masked field above the pending bits and split off whole bytes.
    mask = (int'(w) >= lbp_pkg::VALUE_W) ? '1 : ((32'h1 << w) - 32'h1);
    acc  = (lbp_pkg::ACC_W'(v & mask) << fill) | lbp_pkg::ACC_W'(pending_bits);
    total  = fill + int'(w);
    nbytes = total / 8;
    keep   = (8'h1 << (total % 8)) - 8'h1;
    bit_pos      = bit_pos + lbp_pkg::POS_W'(w);
    pending_bits = 8'(acc >> (nbytes * 8)) & keep;
    if (nbytes == 0) begin
      push_result(8'h00, 1'b0, 1'b0, bit_pos[lbp_pkg::COUNT_W-1:0], 1'b1);
    end else begin
      for (int k = 0; k < nbytes; k++) begin
        push_result(acc[k*8 +: 8], 1'b1, 1'b0, bit_pos[lbp_pkg::COUNT_W-1:0],
                    k == nbytes - 1);
      end
    end
  endfunction

  // Compares one output word with the oldest expectation.
  function void check_result(packer_result_t got);
    packer_result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual byte=%02h valid=%0b",
               $time, got.out_byte, got.byte_valid);
      fail_count++;
      return;
    end
    want = expected_q.pop_front();
    if (got.out_byte !== want.out_byte) begin
      $display("%0t: out_byte expected %02h actual %02h",
               $time, want.out_byte, got.out_byte);
      fail_count++;
    end
    if (got.byte_valid !== want.byte_valid) begin
      $display("%0t: byte_valid expected %0b actual %0b",
               $time, want.byte_valid, got.byte_valid);
      fail_count++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status expected %0b actual %0b", $time, want.status, got.status);
      fail_count++;
    end
    if (got.bit_count !== want.bit_count) begin
      $display("%0t: bit_count expected %0d actual %0d",
               $time, want.bit_count, got.bit_count);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
      fail_count++;
    end
  endfunction
endclass

module tb_lsb_first_bit_packer;

  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_WORDS  = 45;
  localparam int HOLD_AFTER   = 120;
  localparam int HOLD_CYCLES  = 100;

  logic                        clk         = 1'b0;
  logic                        rst         = 1'b1;
  logic                        cfg_write   = 1'b0;
  logic [lbp_pkg::CAP_W-1:0]   cfg_data    = '0;
  logic                        in_valid    = 1'b0;
  logic                        in_stall;
  logic                        op          = lbp_pkg::OP_WRITE;
  logic [lbp_pkg::VALUE_W-1:0] field_value = '0;
  logic [lbp_pkg::WIDTH_W-1:0] field_width = '0;
  logic                        out_valid;
  logic                        out_stall   = 1'b0;
  logic [7:0]                  out_byte;
  logic                        byte_valid;
  logic                        status;
  logic [lbp_pkg::COUNT_W-1:0] bit_count;
  logic                        last;

  bit_stream_scoreboard board = new();
  int unsigned          words_sent = 0;
  bit                   sender_burst = 1'b0;

  lsb_first_bit_packer DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .field_value (field_value),
    .field_width (field_width),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .status      (status),
    .bit_count   (bit_count),
    .last        (last)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Both channels are observed in one place, results first, so the order of
  // expectations never depends on process scheduling.
  always @(posedge clk) begin : monitor
    packer_result_t observed;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        observed.out_byte   = out_byte;
        observed.byte_valid = byte_valid;
        observed.status     = status;
        observed.bit_count  = bit_count;
        observed.last       = last;
        board.check_result(observed);
      end
      if (in_valid && !in_stall) begin
        board.note_word(op, field_value, field_width);
      end
    end
  end

  // Offers one word after a random gap, none in a burst, and returns at the edge that takes it.
  // Valid stays high on return so a back-to-back word needs no second update.
  task automatic send_word(input logic o, input logic [lbp_pkg::VALUE_W-1:0] v,
                           input logic [lbp_pkg::WIDTH_W-1:0] w);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    field_value <= v;
    field_width <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Loads the capacity register once every expected word has come out.
  task automatic set_capacity(input logic [lbp_pkg::CAP_W-1:0] cap);
    in_valid <= 1'b0;
    do @(negedge clk); while (board.expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.capacity_bytes = cap;
  endtask

  // A packet of random fields, mostly closed by a flush, with some noise.
  task automatic send_random_packet();
    int unsigned                 n_fields;
    int unsigned                 pick;
    logic [lbp_pkg::WIDTH_W-1:0] w;
    n_fields     = $urandom_range(1, 12);
    sender_burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n_fields; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_word(lbp_pkg::OP_FLUSH, $urandom, lbp_pkg::WIDTH_W'($urandom));
      end else begin
        if (pick < 8)       w = lbp_pkg::WIDTH_W'($urandom_range(33, 63));
        else if (pick < 13) w = '0;
        else if (pick < 25) w = 6'd32;
        else                w = lbp_pkg::WIDTH_W'($urandom_range(1, 32));
        send_word(lbp_pkg::OP_WRITE, $urandom, w);
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      send_word(lbp_pkg::OP_FLUSH, $urandom, lbp_pkg::WIDTH_W'($urandom));
    end
  endtask

  // Output side: random stalls, runs without stalls, and one long hold-off
  // that backs the block up until it stalls its input.
  initial begin : receiver
    int unsigned hold;
    int unsigned taken;
    int unsigned fast_left;
    bit          long_done;
    taken     = 0;
    fast_left = 0;
    long_done = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!long_done && taken >= HOLD_AFTER) begin
        hold      = HOLD_CYCLES;
        long_done = 1'b1;
      end else if (fast_left > 0) begin
        hold = 0;
        fast_left--;
      end else begin
        hold = $urandom_range(0, 5);
        if ($urandom_range(0, 15) == 0) fast_left = 24;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Main sequence: reset, directed words, then random phases.
  initial begin : stimulus
    logic [lbp_pkg::CAP_W-1:0] phase_caps [5];
    int unsigned               phase_start;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words at the reset capacity: zero width, byte boundaries,
    // full-width fields at odd offsets, masking, errors and flushes.
    send_word(lbp_pkg::OP_WRITE, 32'hFFFF_FFFF, 6'd0);
    send_word(lbp_pkg::OP_WRITE, 32'hFFFF_FFFF, 6'd1);
    send_word(lbp_pkg::OP_WRITE, 32'h0000_0000, 6'd7);
    send_word(lbp_pkg::OP_WRITE, 32'hFFFF_FFFF, 6'd32);
    send_word(lbp_pkg::OP_WRITE, 32'h0000_0005, 6'd3);
    send_word(lbp_pkg::OP_WRITE, 32'hA5A5_A5A5, 6'd32);
    send_word(lbp_pkg::OP_WRITE, 32'h0000_0000, 6'd32);
    send_word(lbp_pkg::OP_WRITE, 32'h1234_5678, 6'd33);
    send_word(lbp_pkg::OP_WRITE, 32'h0000_001F, 6'd5);
    send_word(lbp_pkg::OP_WRITE, 32'h0000_0000, 6'd0);
    send_word(lbp_pkg::OP_FLUSH, 32'hFFFF_FFFF, 6'd63);
    send_word(lbp_pkg::OP_FLUSH, 32'h0000_0000, 6'd0);
    send_word(lbp_pkg::OP_WRITE, 32'h0000_0000, 6'd63);
    send_word(lbp_pkg::OP_FLUSH, 32'h0000_0000, 6'd0);
    send_word(lbp_pkg::OP_WRITE, 32'hFFFF_FFF3, 6'd4);
    send_word(lbp_pkg::OP_WRITE, 32'hFFFF_FF5A, 6'd8);
    send_word(lbp_pkg::OP_FLUSH, 32'h0000_0000, 6'd0);

    // A one-byte packet: exact fill, then overflow by one bit and by a field.
    set_capacity(16'd1);
    send_word(lbp_pkg::OP_WRITE, 32'h0000_001F, 6'd5);
    send_word(lbp_pkg::OP_WRITE, 32'h0000_0000, 6'd3);
    send_word(lbp_pkg::OP_WRITE, 32'h0000_0001, 6'd1);
    send_word(lbp_pkg::OP_FLUSH, 32'h0000_0000, 6'd0);
    send_word(lbp_pkg::OP_WRITE, 32'h0000_01FF, 6'd9);
    send_word(lbp_pkg::OP_FLUSH, 32'h0000_0000, 6'd0);
    send_word(lbp_pkg::OP_WRITE, 32'h0000_00C3, 6'd8);
    send_word(lbp_pkg::OP_FLUSH, 32'h0000_0000, 6'd0);

    // Random packets under a spread of capacities, the extremes included.
    phase_caps[0] = 16'd65535;
    phase_caps[1] = 16'd1;
    phase_caps[2] = lbp_pkg::CAP_W'($urandom_range(2, 16));
    phase_caps[3] = lbp_pkg::CAPACITY_RESET;
    phase_caps[4] = lbp_pkg::CAP_W'($urandom_range(17, 65534));
    for (int p = 0; p < 5; p++) begin
      set_capacity(phase_caps[p]);
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) send_random_packet();
    end

    // Drain and give the block time to show any stray output.
    in_valid <= 1'b0;
    do @(negedge clk); while (board.expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.fail_count == 0 && board.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
